// File: rtl/gprc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gprc_pkg
// Shared types and constants for the gamepad report to RC channel block.
// ----------------------------------------------------------------------------
package gprc_pkg;

	localparam int REPORT_BYTES = 7;
	localparam int AXES         = 4;
	localparam int BUTTONS      = 12;
	localparam int WIDTH_BITS   = 12;
	localparam int PROD_BITS    = 20;

	typedef logic [7:0]            byte_t;
	typedef logic [WIDTH_BITS-1:0] width_t;
	typedef logic [PROD_BITS-1:0]  prod_t;
	typedef logic [BUTTONS-1:0]    buttons_t;

	// configuration register indexes
	localparam logic [0:0] CFG_PPM_LOW = 1'b0;
	localparam logic [0:0] CFG_PPM_MAX = 1'b1;

	localparam width_t PPM_LOW_RST = 12'd1000;
	localparam width_t PPM_MAX_RST = 12'd2000;
	localparam width_t AUX_RST     = 12'd1000;

	localparam byte_t REPORT_RST = 8'h0D;
	localparam byte_t HAT_RST    = 8'hDE;

	localparam logic [3:0] HAT_DOWN = 4'd6;
	localparam logic [3:0] HAT_UP   = 4'd2;
	localparam logic [13:0] HAT_STEP = 14'd300;

	localparam width_t POS_1550 = 12'd1550;
	localparam width_t POS_1900 = 12'd1900;
	localparam width_t POS_2100 = 12'd2100;

endpackage : gprc_pkg
`default_nettype wire

// File: rtl/gprc_axis_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gprc_axis_div
// Divides an axis product by 255 (truncating toward zero) and offsets it by
// the low channel bound.
// ----------------------------------------------------------------------------
module gprc_axis_div (
	input  var gprc_pkg::prod_t  prod,
	input  var logic             neg,
	input  var gprc_pkg::width_t ppm_low,
	output var gprc_pkg::width_t width
);
	import gprc_pkg::*;

	logic [27:0] recip;
	width_t      q0;
	logic [20:0] q0_x255;
	logic [20:0] rem;
	width_t      quot;

	// prod * 257 / 65536 is prod / 255 or one less
	assign recip   = {prod, 8'h00} + {8'h00, prod};
	assign q0      = recip[27:16];
	assign q0_x255 = {1'b0, q0, 8'h00} - {9'h000, q0};
	assign rem     = {1'b0, prod} - q0_x255;
	assign quot    = (rem >= 21'd255) ? q0 + 12'd1 : q0;
	assign width   = neg ? ppm_low - quot : ppm_low + quot;

endmodule : gprc_axis_div
`default_nettype wire

// File: rtl/gamepad_report_to_rc_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_report_to_rc_channels
// Turns 7-byte gamepad reports into eight RC pulse-width channels.
// ----------------------------------------------------------------------------
// One report item is taken per cycle while rpt_stall is low and gives one
// channel item. The first stage registers the report and four axis-by-span
// products; the second stage divides by 255, compares against the kept report
// and applies hat and button updates to the channel registers, which drive
// the channel outputs directly. The user must write ppm_low and ppm_max through
// the cfg port only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module gamepad_report_to_rc_channels (
	input  var logic             clk,
	input  var logic             arst_n,
	input  var logic             cfg_valid,
	output var logic             cfg_ready,
	input  var logic [0:0]       cfg_index,
	input  var gprc_pkg::width_t cfg_data,
	input  var logic             rpt_valid,
	output var logic             rpt_stall,
	input  var gprc_pkg::byte_t  byte_a,
	input  var gprc_pkg::byte_t  byte_b,
	input  var gprc_pkg::byte_t  byte_c,
	input  var gprc_pkg::byte_t  byte_d,
	input  var gprc_pkg::byte_t  byte_e,
	input  var gprc_pkg::byte_t  byte_f,
	input  var gprc_pkg::byte_t  byte_g,
	output var logic             chan_valid,
	input  var logic             chan_stall,
	output var gprc_pkg::width_t pitch_width,
	output var gprc_pkg::width_t roll_width,
	output var gprc_pkg::width_t yaw_width,
	output var gprc_pkg::width_t throttle_width,
	output var gprc_pkg::width_t aux_one_width,
	output var gprc_pkg::width_t aux_two_width,
	output var gprc_pkg::width_t aux_three_width,
	output var gprc_pkg::width_t aux_four_width
);
	import gprc_pkg::*;

	width_t   ppm_low_q;
	width_t   ppm_max_q;
	logic     span_neg;
	width_t   span_mag;

	byte_t    rpt_in [REPORT_BYTES];
	logic     valid_s1;
	byte_t    rpt_s1 [REPORT_BYTES];
	prod_t    prod_s1 [AXES];

	logic     out_valid_q;
	byte_t    last_report_q [REPORT_BYTES];
	byte_t    last_hat_q;
	buttons_t last_buttons_q;
	width_t   axis_q [AXES];
	width_t   aux_one_q;
	width_t   aux_two_q;
	width_t   aux_three_q;

	logic     ld_s1;
	logic     adv_s2;
	logic     changed;
	width_t   axis_new [AXES];
	logic [3:0] hat;
	logic     hat_changed;
	logic [13:0] hat_dn;
	logic [13:0] hat_up;
	width_t   aux_three_hat;
	buttons_t buttons;
	buttons_t pressed;
	width_t   aux_one_nxt;
	width_t   aux_two_nxt;
	width_t   aux_three_nxt;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppm_low_q <= PPM_LOW_RST;
			ppm_max_q <= PPM_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PPM_LOW: ppm_low_q <= cfg_data;
				CFG_PPM_MAX: ppm_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign span_neg = ppm_max_q < ppm_low_q;
	assign span_mag = span_neg ? ppm_low_q - ppm_max_q : ppm_max_q - ppm_low_q;

	// handshake
	assign adv_s2     = valid_s1 && (!out_valid_q || !chan_stall);
	assign rpt_stall  = valid_s1 && !adv_s2;
	assign ld_s1      = rpt_valid && !rpt_stall;
	assign chan_valid = out_valid_q;

	assign rpt_in[0] = byte_a;
	assign rpt_in[1] = byte_b;
	assign rpt_in[2] = byte_c;
	assign rpt_in[3] = byte_d;
	assign rpt_in[4] = byte_e;
	assign rpt_in[5] = byte_f;
	assign rpt_in[6] = byte_g;

	// stage 1: report and axis products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			for (int i = 0; i < REPORT_BYTES; i++) begin
				rpt_s1[i] <= rpt_in[i];
			end
			for (int i = 0; i < AXES; i++) begin
				prod_s1[i] <= prod_t'(rpt_in[3+i]) * prod_t'(span_mag);
			end
		end
	end

	// stage 2: divide, compare and update channels
	for (genvar g = 0; g < AXES; g++) begin : g_axis
		gprc_axis_div u_div (
			.prod    (prod_s1[g]),
			.neg     (span_neg),
			.ppm_low (ppm_low_q),
			.width   (axis_new[g])
		);
	end

	always_comb begin
		changed = 1'b0;
		for (int i = 0; i < REPORT_BYTES; i++) begin
			if (rpt_s1[i] != last_report_q[i]) begin
				changed = 1'b1;
			end
		end
	end

	assign hat         = rpt_s1[2][3:0];
	assign hat_changed = {4'h0, hat} != last_hat_q;
	assign hat_dn      = {2'b00, aux_three_q} - HAT_STEP;
	assign hat_up      = {2'b00, aux_three_q} + HAT_STEP;

	always_comb begin
		aux_three_hat = aux_three_q;
		if (hat_changed) begin
			if (hat == HAT_DOWN) begin
				if ($signed(hat_dn) < $signed({2'b00, ppm_low_q})) begin
					aux_three_hat = ppm_low_q;
				end else begin
					aux_three_hat = hat_dn[11:0];
				end
			end else if (hat == HAT_UP) begin
				if (hat_up > {2'b00, ppm_max_q}) begin
					aux_three_hat = ppm_max_q;
				end else begin
					aux_three_hat = hat_up[11:0];
				end
			end
		end
	end

	assign buttons = {rpt_s1[1][3:0], rpt_s1[0]};
	assign pressed = buttons & ~last_buttons_q;

	// higher-numbered buttons win
	always_comb begin
		aux_one_nxt   = aux_one_q;
		aux_two_nxt   = aux_two_q;
		aux_three_nxt = aux_three_hat;
		if (pressed[11]) begin
			aux_two_nxt = POS_2100;
		end else if (pressed[3]) begin
			aux_two_nxt = POS_1550;
		end else if (pressed[2]) begin
			aux_two_nxt = POS_1900;
		end else if (pressed[0]) begin
			aux_two_nxt = ppm_low_q;
		end
		if (pressed[5]) begin
			aux_one_nxt = ppm_max_q;
		end else if (pressed[4]) begin
			aux_one_nxt = ppm_low_q;
		end
		if (pressed[1]) begin
			aux_three_nxt = POS_2100;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= 1'b1;
		end else if (!chan_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REPORT_BYTES; i++) begin
				last_report_q[i] <= REPORT_RST;
			end
			for (int i = 0; i < AXES; i++) begin
				axis_q[i] <= '0;
			end
			last_hat_q     <= HAT_RST;
			last_buttons_q <= '0;
			aux_one_q      <= AUX_RST;
			aux_two_q      <= AUX_RST;
			aux_three_q    <= AUX_RST;
		end else if (adv_s2) begin
			if (changed) begin
				for (int i = 0; i < REPORT_BYTES; i++) begin
					last_report_q[i] <= rpt_s1[i];
				end
				for (int i = 0; i < AXES; i++) begin
					axis_q[i] <= axis_new[i];
				end
			end
			last_hat_q     <= {4'h0, hat};
			last_buttons_q <= buttons;
			aux_one_q      <= aux_one_nxt;
			aux_two_q      <= aux_two_nxt;
			aux_three_q    <= aux_three_nxt;
		end
	end

	assign pitch_width     = axis_q[0];
	assign roll_width      = axis_q[1];
	assign yaw_width       = axis_q[2];
	assign throttle_width  = axis_q[3];
	assign aux_one_width   = aux_one_q;
	assign aux_two_width   = aux_two_q;
	assign aux_three_width = aux_three_q;
	assign aux_four_width  = AUX_RST;

endmodule : gamepad_report_to_rc_channels
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gamepad_report_to_rc_channels.
// ----------------------------------------------------------------------------
// Reports go in on the report channel and channel items are checked field by
// field against an in-bench model of the kept report, hat, buttons and
// channel registers. A short table of directed reports comes first: all-zero
// and all-ones axes, hat up and down, an ignored hat value, each button alone,
// ignored high nibbles and all buttons at once. After that come random
// segments. Each segment sets ppm_low and ppm_max, including full span,
// inverted span, zero span and equal bounds. Each segment also runs one of
// four mixes: neither, sender gaps, receiver stalls or both.
// ----------------------------------------------------------------------------
module tb;
	import gprc_pkg::*;

	typedef logic [7:0][WIDTH_BITS-1:0] chans_t;
	typedef logic [8*REPORT_BYTES-1:0]  report_t;

	typedef struct packed {
		logic    typed;
		report_t rpt;
		chans_t  res;
	} dir_row_t;

	localparam int DIR_ROWS     = 23;
	localparam int SEGMENTS     = 8;
	localparam int SEG_ITEMS    = 135;
	localparam int SETTLE       = 4;

	localparam int BTN_MODE_LOW = 0;
	localparam int BTN_CAM_HIGH = 1;
	localparam int BTN_MODE_1900 = 2;
	localparam int BTN_MODE_1550 = 3;
	localparam int BTN_GEAR_LOW = 4;
	localparam int BTN_GEAR_HIGH = 5;
	localparam int BTN_MODE_2100 = 11;

	localparam chans_t RES_RESET = {8{12'd1000}};
	localparam chans_t RES_AXES_FULL = {{4{12'd1000}}, {4{12'd2000}}};
	localparam chans_t RES_PREDICTED = '0;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [0:0] cfg_index = CFG_PPM_LOW;
	width_t  cfg_data = '0;
	logic    rpt_valid = 1'b0;
	logic    rpt_stall;
	byte_t   byte_a = '0;
	byte_t   byte_b = '0;
	byte_t   byte_c = '0;
	byte_t   byte_d = '0;
	byte_t   byte_e = '0;
	byte_t   byte_f = '0;
	byte_t   byte_g = '0;
	logic    chan_valid;
	logic    chan_stall = 1'b0;
	width_t  pitch_width;
	width_t  roll_width;
	width_t  yaw_width;
	width_t  throttle_width;
	width_t  aux_one_width;
	width_t  aux_two_width;
	width_t  aux_three_width;
	width_t  aux_four_width;

	gamepad_report_to_rc_channels i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.rpt_valid       (rpt_valid),
		.rpt_stall       (rpt_stall),
		.byte_a          (byte_a),
		.byte_b          (byte_b),
		.byte_c          (byte_c),
		.byte_d          (byte_d),
		.byte_e          (byte_e),
		.byte_f          (byte_f),
		.byte_g          (byte_g),
		.chan_valid      (chan_valid),
		.chan_stall      (chan_stall),
		.pitch_width     (pitch_width),
		.roll_width      (roll_width),
		.yaw_width       (yaw_width),
		.throttle_width  (throttle_width),
		.aux_one_width   (aux_one_width),
		.aux_two_width   (aux_two_width),
		.aux_three_width (aux_three_width),
		.aux_four_width  (aux_four_width)
	);

	// model state
	width_t   ppm_lo;
	width_t   ppm_hi;
	byte_t    kept_report [REPORT_BYTES];
	byte_t    kept_hat;
	buttons_t kept_buttons;
	width_t   axis_chan [AXES];
	width_t   aux_chan [4];

	chans_t   expected_channels [$];
	int       mismatch_count = 0;
	int       idle_pct = 0;
	int       stall_pct = 0;
	string    chan_names [8] = '{"pitch", "roll", "yaw", "throttle",
		"aux_one", "aux_two", "aux_three", "aux_four"};
	dir_row_t dir_rows [DIR_ROWS];
	width_t   seg_lo [SEGMENTS] = '{12'd0, 12'd4095, 12'd1500, 12'd0,
		12'd4095, 12'd1000, 12'd0, 12'd0};
	width_t   seg_hi [SEGMENTS] = '{12'd4095, 12'd0, 12'd1200, 12'd0,
		12'd4095, 12'd2000, 12'd0, 12'd0};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[gamepad_report_to_rc_channels] ERROR");
		$finish;
	end

	function automatic width_t scale_axis(byte_t x);
		int lo;
		int span;
		int v;
		lo = int'(ppm_lo);
		span = int'(ppm_hi) - lo;
		v = lo + (int'(x) * span) / 255;
		return width_t'(v);
	endfunction

	function automatic chans_t predict_channels(report_t rpt);
		byte_t      rep [REPORT_BYTES];
		logic       changed;
		logic [3:0] hat;
		buttons_t   btn;
		buttons_t   pressed;
		int         a;
		int         i;
		chans_t     res;
		changed = 1'b0;
		for (i = 0; i < REPORT_BYTES; i++) begin
			rep[i] = rpt[8*(REPORT_BYTES-1-i) +: 8];
			if (rep[i] != kept_report[i])
				changed = 1'b1;
		end
		if (changed) begin
			for (i = 0; i < AXES; i++)
				axis_chan[i] = scale_axis(rep[3+i]);
			for (i = 0; i < REPORT_BYTES; i++)
				kept_report[i] = rep[i];
		end
		hat = rep[2][3:0];
		if ({4'h0, hat} != kept_hat) begin
			a = int'(aux_chan[2]);
			if (hat == HAT_DOWN) begin
				a -= int'(HAT_STEP);
				if (a < int'(ppm_lo))
					a = int'(ppm_lo);
			end else if (hat == HAT_UP) begin
				a += int'(HAT_STEP);
				if (a > int'(ppm_hi))
					a = int'(ppm_hi);
			end
			aux_chan[2] = width_t'(a);
			kept_hat = {4'h0, hat};
		end
		btn = {rep[1][3:0], rep[0]};
		pressed = btn & ~kept_buttons;
		for (i = 0; i < BUTTONS; i++) begin
			if (pressed[i]) begin
				case (i)
					BTN_MODE_LOW:  aux_chan[1] = ppm_lo;
					BTN_CAM_HIGH:  aux_chan[2] = POS_2100;
					BTN_MODE_1900: aux_chan[1] = POS_1900;
					BTN_MODE_1550: aux_chan[1] = POS_1550;
					BTN_GEAR_LOW:  aux_chan[0] = ppm_lo;
					BTN_GEAR_HIGH: aux_chan[0] = ppm_hi;
					BTN_MODE_2100: aux_chan[1] = POS_2100;
					default: ;
				endcase
			end
		end
		kept_buttons = btn;
		for (i = 0; i < 4; i++) begin
			res[i] = axis_chan[i];
			res[4+i] = aux_chan[i];
		end
		return res;
	endfunction

	function automatic report_t random_report(report_t prev);
		report_t rpt;
		int      k;
		int      i;
		int      r;
		byte_t   x;
		k = $urandom_range(0, 99);
		if (k < 12)
			return prev;
		rpt = prev;
		if (k < 55) begin
			// toggle one button bit
			r = $urandom_range(0, BUTTONS - 1);
			if (r < 8)
				rpt[48 + r] = ~rpt[48 + r];
			else
				rpt[40 + r - 8] = ~rpt[40 + r - 8];
			if ($urandom_range(0, 3) == 0)
				rpt[47:44] = 4'($urandom);
		end else begin
			rpt[55:40] = 16'($urandom);
		end
		case ($urandom_range(0, 4))
			0: rpt[39:32] = {4'($urandom), HAT_UP};
			1: rpt[39:32] = {4'($urandom), HAT_DOWN};
			2: rpt[39:32] = {4'($urandom), 4'h0};
			3: rpt[39:32] = prev[39:32];
			default: rpt[39:32] = 8'($urandom);
		endcase
		if (k >= 35) begin
			for (i = 0; i < AXES; i++) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					x = 8'h00;
				else if (r < 20)
					x = 8'hFF;
				else
					x = 8'($urandom);
				rpt[8*(AXES-1-i) +: 8] = x;
			end
		end
		return rpt;
	endfunction

	task automatic send_report(report_t rpt, logic typed, chans_t typed_res);
		chans_t res;
		while ($urandom_range(0, 99) < idle_pct) begin
			rpt_valid <= 1'b0;
			@(posedge clk);
		end
		{byte_a, byte_b, byte_c, byte_d, byte_e, byte_f, byte_g} <= rpt;
		rpt_valid <= 1'b1;
		do @(posedge clk); while (rpt_stall !== 1'b0);
		res = predict_channels(rpt);
		expected_channels.push_back(typed ? typed_res : res);
	endtask

	task automatic drain_channels();
		rpt_valid <= 1'b0;
		while (expected_channels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_ppm(width_t lo, width_t hi);
		cfg_index <= CFG_PPM_LOW;
		cfg_data <= lo;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_index <= CFG_PPM_MAX;
		cfg_data <= hi;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		ppm_lo = lo;
		ppm_hi = hi;
	endtask

	// channel item checker and receiver stall
	always @(posedge clk) begin
		chans_t got;
		chans_t want;
		int     i;
		if (arst_n && chan_valid === 1'b1 && chan_stall === 1'b0) begin
			got = {aux_four_width, aux_three_width, aux_two_width, aux_one_width,
				throttle_width, yaw_width, roll_width, pitch_width};
			if (expected_channels.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected channel item, expected none, actual %h",
					$time, got);
			end else begin
				want = expected_channels.pop_front();
				for (i = 0; i < 8; i++) begin
					if (got[i] !== want[i]) begin
						mismatch_count++;
						$display("%0t %s expected %0d actual %0d", $time,
							chan_names[i], want[i], got[i]);
					end
				end
			end
		end
		chan_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		report_t prev;
		int      seg;
		int      n;
		int      i;
		ppm_lo = PPM_LOW_RST;
		ppm_hi = PPM_MAX_RST;
		for (i = 0; i < REPORT_BYTES; i++)
			kept_report[i] = REPORT_RST;
		kept_hat = HAT_RST;
		kept_buttons = '0;
		for (i = 0; i < 4; i++) begin
			axis_chan[i] = '0;
			aux_chan[i] = AUX_RST;
		end
		dir_rows = '{
			{1'b1, 56'h00_00_00_00_00_00_00, RES_RESET},
			{1'b1, 56'h00_00_F0_FF_FF_FF_FF, RES_AXES_FULL},
			{1'b0, 56'h00_00_F0_FF_FF_FF_FF, RES_PREDICTED},
			{1'b0, 56'h00_00_02_80_40_C0_01, RES_PREDICTED},
			{1'b0, 56'h00_00_02_80_40_C0_01, RES_PREDICTED},
			{1'b0, 56'h00_00_06_80_40_C0_01, RES_PREDICTED},
			{1'b0, 56'h00_00_0F_7F_3F_BF_FE, RES_PREDICTED},
			{1'b0, 56'h00_00_A2_7F_3F_BF_FE, RES_PREDICTED},
			{1'b0, 56'h01_00_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h02_00_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h04_00_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h08_00_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h10_00_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h20_00_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h40_00_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h80_00_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h00_01_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h00_02_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h00_04_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h00_08_A2_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'h00_F0_F6_11_22_33_44, RES_PREDICTED},
			{1'b0, 56'hFF_0F_06_AA_55_AA_55, RES_PREDICTED},
			{1'b0, 56'h00_00_00_7F_80_01_FE, RES_PREDICTED}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			send_report(dir_rows[i].rpt, dir_rows[i].typed, dir_rows[i].res);
		prev = dir_rows[DIR_ROWS-1].rpt;
		drain_channels();

		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg >= 6)
				write_ppm(width_t'($urandom_range(0, 4095)),
					width_t'($urandom_range(0, 4095)));
			else
				write_ppm(seg_lo[seg], seg_hi[seg]);
			case (seg % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 47; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 47; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			for (n = 0; n < SEG_ITEMS; n++) begin
				// hold off until the pipeline has emptied
				if (seg == 3 && n == SEG_ITEMS / 2)
					drain_channels();
				prev = random_report(prev);
				send_report(prev, 1'b0, RES_PREDICTED);
			end
			drain_channels();
		end

		if (mismatch_count == 0 && expected_channels.size() == 0)
			$display("[gamepad_report_to_rc_channels] OK");
		else
			$display("[gamepad_report_to_rc_channels] ERROR");
		$finish;
	end

endmodule : tb
`default_nettype wire

// File: files.f
rtl/gprc_pkg.sv
rtl/gprc_axis_div.sv
rtl/gamepad_report_to_rc_channels.sv
tb/tb.sv
